FILE: hdl/mor_pkg.sv
// ----------------------------------------------------------------------------
// mor_pkg
// Shared types and constants for the maximal ones rectangle row engine.
// ----------------------------------------------------------------------------
package mor_pkg;

  localparam int ROW_W      = 32;         // width of one matrix row item
  localparam int CFG_W      = 6;          // width of the column count register
  localparam int AREA_W     = 16;         // width of the reported area
  localparam int COLS_RESET = 32;         // column count after reset
  localparam int GROUP      = 8;          // lanes merged per group in the first max stage

  localparam logic [AREA_W-1:0] AREA_CAP = '1;

  // Per-row control broadcast from the sequencer to every column lane.
  typedef struct packed {
    logic update;   // a row is being applied this cycle
    logic first;    // the row opens a new matrix
  } lane_ctl_t;

endpackage

FILE: hdl/max_ones_rectangle_rows.sv
// ----------------------------------------------------------------------------
// max_ones_rectangle_rows
// Largest all-ones rectangle in a binary matrix streamed one row per transfer.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake             Payload
//  -------  --------------------  ----------------------------------
//  in       in_valid / in_stall   row_bits[31:0], first_row
//  out      out_valid / out_stall best_area[15:0]
//  cfg      cfg_valid / cfg_ready cfg_data[5:0] (columns in use)
//
//  An item is registered, applied to all column lanes at once, reduced to group
//  maxima, and merged with the running best into the output register. The
//  pipeline holds one row at a time; a new row is taken once the last has left
//  the last stage. Reset is synchronous and needs no clearing pass. A stall on
//  the output holds the last stage until the result is taken.
//
// Each column is a lane holding its run height and the left and right bounds
// of the widest band of that height. The lanes find the bounds of their run of
// ones in the current row with a prefix scan over the row, update their state
// and register their own area. A two-level maximum then folds the lane areas
// into the best area of the matrix so far.
// ----------------------------------------------------------------------------
module max_ones_rectangle_rows #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mor_pkg::ROW_W-1:0]         row_bits,
  input  logic                              first_row,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mor_pkg::AREA_W-1:0]        best_area,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mor_pkg::CFG_W-1:0]         cfg_data
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int HW = $clog2(MAX_ROWS + 1);

  logic [mor_pkg::CFG_W-1:0] cols_in_use;
  logic [mor_pkg::CFG_W:0]   n_act;
  logic [CW-1:0]             nm1;

  logic                      v1, v2, v3;
  logic                      f1, f2, f3;
  logic [mor_pkg::ROW_W-1:0] row;
  logic                      in_xfer, fin;

  logic [MAX_COLS-1:0]       act, cells;
  logic [mor_pkg::AREA_W-1:0] areas [MAX_COLS];
  mor_pkg::lane_ctl_t        ctl;

  assign cfg_ready = 1'b1;
  assign in_stall  = v1 | v2 | v3;
  assign in_xfer   = in_valid & ~in_stall;
  assign fin       = v3 & ~(out_valid & out_stall);

  // The column count is clamped into the range the lanes cover.
  always_comb begin
    if (cols_in_use == '0) begin
      n_act = (mor_pkg::CFG_W+1)'(1);
    end else if ({1'b0, cols_in_use} > (mor_pkg::CFG_W+1)'(MAX_COLS)) begin
      n_act = (mor_pkg::CFG_W+1)'(MAX_COLS);
    end else begin
      n_act = {1'b0, cols_in_use};
    end
    nm1 = CW'(n_act - (mor_pkg::CFG_W+1)'(1));
  end

  // Columns past the count, or past the row word, read as zero cells.
  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      act[j]   = (mor_pkg::CFG_W+1)'(j) < n_act;
      cells[j] = act[j] & ((j < mor_pkg::ROW_W) ? row[j % mor_pkg::ROW_W] : 1'b0);
    end
  end

  assign ctl.update = v1;
  assign ctl.first  = f1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= mor_pkg::CFG_W'(mor_pkg::COLS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      cols_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_xfer;
      v2 <= v1;
      if (v2) begin
        v3 <= 1'b1;
      end else if (fin) begin
        v3 <= 1'b0;
      end
      if (fin) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      row <= row_bits;
      f1  <= first_row;
    end
    if (v1) f2 <= f1;
    if (v2) f3 <= f2;
  end

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
    mor_lane #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .IDX      (c),
      .CW       (CW),
      .HW       (HW)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .cells  (cells),
      .active (act[c]),
      .nm1    (nm1),
      .area   (areas[c])
    );
  end

  mor_merge #(
    .MAX_COLS (MAX_COLS)
  ) u_merge (
    .clk    (clk),
    .rst    (rst),
    .areas  (areas),
    .grp_en (v2),
    .fin_en (fin),
    .first  (f3),
    .best   (best_area)
  );

  a_one_stage: assert property (@(posedge clk) disable iff (rst) $onehot0({v1, v2, v3}))
    else $error("more than one pipeline stage holds a row");
  a_take: assert property (@(posedge clk) disable iff (rst) in_xfer |=> v1)
    else $error("accepted row did not enter the lanes");
  a_lanes: assert property (@(posedge clk) disable iff (rst) v1 |=> v2 && !v1)
    else $error("lane stage did not pass on to the merge");
  a_result: assert property (@(posedge clk) disable iff (rst) fin |=> out_valid && !v3)
    else $error("finished row did not reach the output");

endmodule

FILE: hdl/mor_lane.sv
// ----------------------------------------------------------------------------
// mor_lane
// One column lane: keeps height and bounds of its column and forms its area.
// ----------------------------------------------------------------------------
module mor_lane #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 1024,
  parameter int IDX      = 0,
  parameter int CW       = 5,
  parameter int HW       = 11
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mor_pkg::lane_ctl_t              ctl,
  input  logic [MAX_COLS-1:0]             cells,
  input  logic                            active,
  input  logic [CW-1:0]                   nm1,
  output logic [mor_pkg::AREA_W-1:0]      area
);

  localparam int RST_N = (MAX_COLS < mor_pkg::COLS_RESET) ? MAX_COLS : mor_pkg::COLS_RESET;
  localparam int PW    = CW + 1 + HW;

  logic [HW-1:0] height, height_next;
  logic [CW-1:0] left, left_next;
  logic [CW-1:0] right, right_next;
  logic [mor_pkg::AREA_W-1:0] area_next;

  logic [HW-1:0] h0;
  logic [CW-1:0] l0, r0, rs, re;
  logic signed [CW+1:0] wd;
  logic [PW-1:0] prod;
  logic [PW+mor_pkg::AREA_W-1:0] prod_ext;

  // Start of the current run of ones (left) and its end (right).
  always_comb begin
    rs = '0;
    for (int j = 0; j < IDX; j++) begin
      if (!cells[j]) rs = CW'(j + 1);
    end
    re = nm1;
    for (int j = MAX_COLS - 1; j > IDX; j--) begin
      if (!cells[j]) re = CW'(j - 1);
    end
  end

  always_comb begin
    h0 = ctl.first ? '0 : height;
    l0 = ctl.first ? '0 : left;
    r0 = ctl.first ? nm1 : right;
    height_next = h0;
    left_next   = l0;
    right_next  = r0;
    area_next   = '0;
    wd          = '0;
    prod        = '0;
    prod_ext    = '0;
    if (active) begin
      if (cells[IDX]) begin
        height_next = (h0 < HW'(MAX_ROWS)) ? h0 + HW'(1) : h0;
        left_next   = (l0 < rs) ? rs : l0;
        right_next  = (r0 > re) ? re : r0;
        wd = $signed({2'b00, right_next}) - $signed({2'b00, left_next})
             + $signed((CW+2)'(1));
        prod     = PW'(wd[CW:0]) * PW'(height_next);
        prod_ext = (PW+mor_pkg::AREA_W)'(prod);
        // A bound pair left crossed by a column count change gives a negative
        // width, which wraps to a huge area and so saturates.
        if (wd[CW+1]) begin
          area_next = mor_pkg::AREA_CAP;
        end else if (prod_ext > (PW+mor_pkg::AREA_W)'(mor_pkg::AREA_CAP)) begin
          area_next = mor_pkg::AREA_CAP;
        end else begin
          area_next = prod_ext[mor_pkg::AREA_W-1:0];
        end
      end else begin
        height_next = '0;
        left_next   = '0;
        right_next  = nm1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      height <= '0;
      left   <= '0;
      right  <= CW'(RST_N - 1);
      area   <= '0;
    end else if (ctl.update) begin
      height <= height_next;
      left   <= left_next;
      right  <= right_next;
      area   <= area_next;
    end
  end

endmodule

FILE: hdl/mor_merge.sv
// ----------------------------------------------------------------------------
// mor_merge
// Two-stage registered maximum over the lane areas and the running best.
// ----------------------------------------------------------------------------
module mor_merge #(
  parameter int MAX_COLS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mor_pkg::AREA_W-1:0]  areas [MAX_COLS],
  input  logic                        grp_en,
  input  logic                        fin_en,
  input  logic                        first,
  output logic [mor_pkg::AREA_W-1:0]  best
);

  localparam int NG = (MAX_COLS + mor_pkg::GROUP - 1) / mor_pkg::GROUP;

  logic [mor_pkg::AREA_W-1:0] gmax [NG];
  logic [mor_pkg::AREA_W-1:0] gmax_next [NG];
  logic [mor_pkg::AREA_W-1:0] best_next;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gmax_next[g] = '0;
      for (int k = 0; k < mor_pkg::GROUP; k++) begin
        if (g * mor_pkg::GROUP + k < MAX_COLS) begin
          if (areas[g * mor_pkg::GROUP + k] > gmax_next[g]) begin
            gmax_next[g] = areas[g * mor_pkg::GROUP + k];
          end
        end
      end
    end
  end

  always_comb begin
    best_next = first ? '0 : best;
    for (int g = 0; g < NG; g++) begin
      if (gmax[g] > best_next) best_next = gmax[g];
    end
  end

  always_ff @(posedge clk) begin
    if (grp_en) begin
      gmax <= gmax_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best <= '0;
    end else if (fin_en) begin
      best <= best_next;
    end
  end

endmodule

FILE: tb/sv/tb_max_ones_rectangle_rows.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_max_ones_rectangle_rows
// Self-checking bench for the streaming largest all-ones rectangle engine.
// ----------------------------------------------------------------------------
// Matrices are streamed one row per transfer with random content, random
// heights and several column counts. A behavioural copy of the column state
// predicts the best area after every row, and each result is compared with
// the oldest prediction. Both channels idle at random, and one long output
// hold-off forces the engine to stall its input.
// ----------------------------------------------------------------------------
module tb_max_ones_rectangle_rows;

  localparam int NCOLS     = 32;
  localparam int NROWS_MAX = 1024;
  localparam int AREA_SAT  = 65535;
  localparam int WD_LIMIT  = 5000;

  typedef struct packed {
    logic [mor_pkg::ROW_W-1:0] bits;
    logic                      first;
  } row_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [mor_pkg::ROW_W-1:0]  row_bits = '0;
  logic                       first_row = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [mor_pkg::AREA_W-1:0] best_area;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [mor_pkg::CFG_W-1:0]  cfg_data = '0;

  max_ones_rectangle_rows dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .row_bits(row_bits), .first_row(first_row),
    .out_valid(out_valid), .out_stall(out_stall), .best_area(best_area),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rows waiting to be driven, and areas waiting to be seen.
  row_item_t   pending_rows[$];
  logic [15:0] area_queue[$];

  // Behavioural copy of the engine state.
  int          col_count_reg;
  int          heights[NCOLS];
  int          lefts[NCOLS];
  int          rights[NCOLS];
  int          best_seen;

  int errors    = 0;
  int rows_sent = 0;
  int areas_got = 0;
  int idle_pct  = 10;
  int hold_off  = 0;    // long receiver hold-off, counted by the monitor
  bit feeding   = 1'b0;

  function automatic int cols_active();
    int n;
    n = col_count_reg;
    if (n < 1) n = 1;
    if (n > NCOLS) n = NCOLS;
    return n;
  endfunction

  function automatic void clear_matrix();
    int n;
    n = cols_active();
    for (int c = 0; c < NCOLS; c++) begin
      heights[c] = 0;
      lefts[c]   = 0;
      rights[c]  = n - 1;
    end
    best_seen = 0;
  endfunction

  // Apply one row to the column state and return the running best area.
  function automatic logic [15:0] apply_row(row_item_t it);
    int n, run_start, run_end, w, a;
    if (it.first) clear_matrix();
    n = cols_active();
    run_start = 0;
    for (int c = 0; c < n; c++) begin
      if (it.bits[c]) begin
        if (lefts[c] < run_start) lefts[c] = run_start;
      end else begin
        lefts[c]  = 0;
        run_start = c + 1;
      end
    end
    run_end = n - 1;
    for (int c = n - 1; c >= 0; c--) begin
      if (it.bits[c]) begin
        if (heights[c] < NROWS_MAX) heights[c]++;
        if (rights[c] > run_end) rights[c] = run_end;
        w = rights[c] - lefts[c] + 1;
        a = w * heights[c];
        // Crossed bounds give a negative width, which saturates the area.
        if (a < 0) a = AREA_SAT;
        if (a > AREA_SAT) a = AREA_SAT;
        if (a > best_seen) best_seen = a;
      end else begin
        heights[c] = 0;
        rights[c]  = n - 1;
        run_end    = c - 1;
      end
    end
    return best_seen[15:0];
  endfunction

  // Driver: takes the next row from the queue once the current one is accepted.
  // The prediction is made at acceptance, so the order matches the engine.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        area_queue.push_back(apply_row(row_item_t'{row_bits, first_row}));
        rows_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (feeding && pending_rows.size() > 0 &&
            $urandom_range(99) >= idle_pct) begin
          row_item_t it;
          it = pending_rows.pop_front();
          row_bits  <= it.bits;
          first_row <= it.first;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and drives the output stall.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        areas_got++;
        if (area_queue.size() == 0) begin
          $display("%0t: unexpected area, expected none, actual %0d", $time, best_area);
          errors++;
        end else begin
          logic [15:0] want;
          want = area_queue.pop_front();
          if (want !== best_area) begin
            $display("%0t: best_area mismatch, expected %0d, actual %0d",
                     $time, want, best_area);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off  <= hold_off - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  // Watchdog: cycles without any transfer on either channel.
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      quiet <= 0;
    else if (quiet >= WD_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WD_LIMIT);
      $display("** max_ones_rectangle_rows: FAILED **");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  // Write the column count while the engine is idle and mirror it.
  task automatic write_cols(int value);
    @(posedge clk);
    cfg_data  <= value[mor_pkg::CFG_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    col_count_reg = value & 6'h3f;
  endtask

  // Hand the queued rows to the driver and wait for every result.
  task automatic run_phase();
    feeding = 1'b1;
    wait (pending_rows.size() == 0);
    @(posedge clk);
    while (in_valid || area_queue.size() > 0) @(posedge clk);
    feeding = 1'b0;
    repeat (8) @(posedge clk);
  endtask

  function automatic void add_row(logic [31:0] b, logic f);
    pending_rows.push_back('{b, f});
  endfunction

  // A matrix of random height; mostly dense rows so tall rectangles appear.
  function automatic void add_matrix(int h, int density);
    logic [31:0] b;
    logic [31:0] base;
    base = $urandom;
    for (int r = 0; r < h; r++) begin
      b = 0;
      for (int k = 0; k < 32; k++)
        b[k] = ($urandom_range(99) < density);
      if ($urandom_range(1)) b = b | (base & $urandom);
      add_row(b, r == 0 ? 1'b1 : ($urandom_range(199) == 0));
    end
  endfunction

  initial begin
    int count_list[7];
    count_list = '{32, 1, 0, 63, 17, 5, 32};
    col_count_reg = mor_pkg::COLS_RESET;
    clear_matrix();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: extremes, the first-row clear and a mid-matrix count change.
    add_row(32'h0000_0000, 1'b1);
    add_row(32'hFFFF_FFFF, 1'b0);
    add_row(32'hFFFF_FFFF, 1'b0);
    add_row(32'h8000_0001, 1'b0);
    add_row(32'h0FF0_0FF0, 1'b0);
    add_row(32'hFFFF_FFFF, 1'b1);
    add_row(32'hAAAA_AAAA, 1'b0);
    add_row(32'h5555_5555, 1'b0);
    add_row(32'hFFFF_0000, 1'b0);
    add_row(32'h0000_FFFF, 1'b0);
    run_phase();
    write_cols(8);   // the count changes with the matrix still open
    add_row(32'hFFFF_FFFF, 1'b0);
    add_row(32'h0000_00F0, 1'b0);
    add_row(32'h0000_0000, 1'b0);
    run_phase();

    // A tall all-ones matrix drives every column height to saturation.
    write_cols(32);
    for (int r = 0; r < 1030; r++) add_row(32'hFFFF_FFFF, r == 0);
    idle_pct = 0;
    run_phase();
    idle_pct = 10;

    // Random matrices across several column counts, including the extremes.
    foreach (count_list[i]) begin
      write_cols(count_list[i]);
      repeat (8) add_matrix($urandom_range(2, 12), $urandom_range(40, 95));
      add_matrix(4, 20);
      if (i == 2) idle_pct = 0;   // a stretch with no idling at all
      if (i == 3) begin
        idle_pct = 10;
        hold_off = 300;           // output held so the input backs up
      end
      run_phase();
    end

    $display("Rows applied: %0d, areas checked: %0d, column counts 0 to 63 with",
             rows_sent, areas_got);
    $display("height saturation and a long output stall covered.");
    if (errors == 0) begin
      $display("** max_ones_rectangle_rows: PASSED **");
    end else begin
      $display("** max_ones_rectangle_rows: FAILED **");
    end
    $finish;
  end

endmodule
